// ----- hdl/tfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tfs_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int QUEUE_LEN       = 6;

   localparam int SECTOR_UNITS = 60 << ANGLE_FRAC_BITS;
   localparam int SHIFT_UNITS  = 30 << ANGLE_FRAC_BITS;
   localparam int ANGLE_MAX    = QUEUE_LEN * SECTOR_UNITS - 1;

   localparam int ALPHA_W  = 16;
   localparam int PW_W     = 12;
   localparam int TICK_W   = 16;
   localparam int SRC_W    = 3;
   localparam int GATE_W   = 6;
   localparam int SECTOR_W = 3;

   localparam int ANGLE_W  = $clog2(QUEUE_LEN * SECTOR_UNITS);
   localparam int SUM_W    = (ANGLE_W + 1 > ALPHA_W + 1) ? ANGLE_W + 1 : ALPHA_W + 1;
   localparam int REM_W    = $clog2(SECTOR_UNITS);
   localparam int UNIT_W   = $clog2(2 * SECTOR_UNITS);
   localparam int PSUM_W   = ((REM_W > PW_W) ? REM_W : PW_W) + 1;
   localparam int ACC_W    = $clog2(4 * SECTOR_UNITS);
   localparam int QUOT_W   = TICK_W + 2;
   localparam int CNT_W    = $clog2(TICK_W);

   localparam int REQ_W = 48;
   localparam int RSP_W = 48;
   localparam int RSP_USED_W = GATE_W + 2 * TICK_W + 1 + SECTOR_W;

   localparam logic [GATE_W-1:0] G_AP = 6'h01;
   localparam logic [GATE_W-1:0] G_BP = 6'h02;
   localparam logic [GATE_W-1:0] G_CP = 6'h04;
   localparam logic [GATE_W-1:0] G_AM = 6'h08;
   localparam logic [GATE_W-1:0] G_BM = 6'h10;
   localparam logic [GATE_W-1:0] G_CM = 6'h20;

   typedef enum logic [1:0] {
      OP_SET_ANGLE = 2'd0,
      OP_SYNC      = 2'd1,
      OP_PULSE_ON  = 2'd2,
      OP_PULSE_OFF = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_REVERSE_SEQUENCE = 1'b0,
      CSR_SEMISTOR_MODE    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SECTOR,
      ST_START,
      ST_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [UNIT_W-1:0] units;
      logic [TICK_W-1:0] ticks;
   } tick_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [TICK_W-1:0] result;
   } tick_stat_type;

   typedef struct packed {
      logic                update;
      opcode_type          opcode;
      logic [SRC_W-1:0]    source;
      logic [SECTOR_W-1:0] sector;
      logic                carry;
      logic                reverse;
   } gate_ctrl_type;

   function automatic logic [SECTOR_W-1:0] sync_lookup(input logic rev,
                                                       input logic [SRC_W-1:0] src);
      logic [SECTOR_W-1:0] pos;
      pos = '0;
      unique case (src)
         3'd0: pos = 3'd0;
         3'd1: pos = 3'd3;
         3'd2: pos = rev ? 3'd4 : 3'd2;
         3'd3: pos = rev ? 3'd1 : 3'd5;
         3'd4: pos = rev ? 3'd2 : 3'd4;
         3'd5: pos = rev ? 3'd5 : 3'd1;
         default: pos = '0;
      endcase
      return pos;
   endfunction

   function automatic logic [GATE_W-1:0] fire_lookup(input logic rev,
                                                     input logic [SECTOR_W-1:0] idx);
      logic [GATE_W-1:0] pair;
      pair = '0;
      unique case (idx)
         3'd0: pair = rev ? (G_AP | G_CM) : (G_AP | G_BM);
         3'd1: pair = rev ? (G_AP | G_BM) : (G_AP | G_CM);
         3'd2: pair = rev ? (G_CP | G_BM) : (G_BP | G_CM);
         3'd3: pair = rev ? (G_CP | G_AM) : (G_BP | G_AM);
         3'd4: pair = rev ? (G_BP | G_AM) : (G_CP | G_AM);
         3'd5: pair = rev ? (G_BP | G_CM) : (G_CP | G_BM);
         default: pair = '0;
      endcase
      return pair;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/tfs_tick_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tfs_tick_unit (
   input  wire                         clock,
   input  wire                         reset,
   input  wire tfs_pkg::tick_ctrl_type ctrl,
   output tfs_pkg::tick_stat_type      stat
);
   import tfs_pkg::*;

   localparam logic [ACC_W-1:0] ACC_S1 = ACC_W'(SECTOR_UNITS);
   localparam logic [ACC_W-1:0] ACC_S2 = ACC_W'(2 * SECTOR_UNITS);
   localparam logic [ACC_W-1:0] ACC_S3 = ACC_W'(3 * SECTOR_UNITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [UNIT_W-1:0] units_ff, units_in;
   logic [TICK_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [ACC_W-1:0]  acc;
   logic [ACC_W-1:0]  acc_sub;
   logic [1:0]        digit;

   always_comb begin
      acc = ACC_W'({rem_ff, 1'b0}) + (shift_ff[TICK_W-1] ? ACC_W'(units_ff) : '0);
      if (acc >= ACC_S3) begin
         digit   = 2'd3;
         acc_sub = acc - ACC_S3;
      end else if (acc >= ACC_S2) begin
         digit   = 2'd2;
         acc_sub = acc - ACC_S2;
      end else if (acc >= ACC_S1) begin
         digit   = 2'd1;
         acc_sub = acc - ACC_S1;
      end else begin
         digit   = 2'd0;
         acc_sub = acc;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      units_in = units_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         units_in = ctrl.units;
         shift_in = ctrl.ticks;
         rem_in   = '0;
         quot_in  = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[TICK_W-2:0], 1'b0};
         rem_in   = acc_sub[REM_W-1:0];
         quot_in  = QUOT_W'({quot_ff, 1'b0}) + QUOT_W'(digit);
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      units_ff <= units_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = (|quot_ff[QUOT_W-1:TICK_W]) ? '1 : quot_ff[TICK_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/tfs_gate_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tfs_gate_seq (
   input  wire                             clock,
   input  wire                             reset,
   input  wire tfs_pkg::gate_ctrl_type     ctrl,
   output logic [tfs_pkg::GATE_W-1:0]      gate_mask
);
   import tfs_pkg::*;

   localparam logic [SECTOR_W-1:0] QLEN = SECTOR_W'(QUEUE_LEN);

   logic [GATE_W-1:0]   expected_ff, expected_in;
   logic [GATE_W-1:0]   gate_ff, gate_in;
   logic [SECTOR_W-1:0] sec_mod;
   logic [SECTOR_W:0]   pos_sum;
   logic [SECTOR_W-1:0] idx;
   logic [SECTOR_W-1:0] idx_prev;

   always_comb begin
      sec_mod  = (ctrl.sector >= QLEN) ? ctrl.sector - QLEN : ctrl.sector;
      pos_sum  = {1'b0, sync_lookup(ctrl.reverse, ctrl.source)} + {1'b0, QLEN}
                 - {1'b0, sec_mod};
      idx      = (pos_sum >= {1'b0, QLEN}) ? SECTOR_W'(pos_sum - {1'b0, QLEN})
                                           : pos_sum[SECTOR_W-1:0];
      idx_prev = (idx == '0) ? QLEN - 1'b1 : idx - 1'b1;
   end

   always_comb begin
      expected_in = expected_ff;
      gate_in     = gate_ff;
      if (ctrl.update) begin
         unique case (ctrl.opcode)
            OP_SYNC: begin
               if (ctrl.source < SRC_W'(QUEUE_LEN)) begin
                  expected_in = fire_lookup(ctrl.reverse, idx);
                  gate_in     = ctrl.carry ? fire_lookup(ctrl.reverse, idx_prev) : '0;
               end
            end
            OP_PULSE_ON:  gate_in = expected_ff;
            OP_PULSE_OFF: gate_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         gate_ff     <= '0;
      end else begin
         expected_ff <= expected_in;
         gate_ff     <= gate_in;
      end
   end

   assign gate_mask = gate_ff;

   a_gate_pair: assert property (@(posedge clock) disable iff (reset)
      ($countones(gate_ff) == 0) || ($countones(gate_ff) == 2))
      else $error("gate drive is not a single thyristor pair");
   a_expected_pair: assert property (@(posedge clock) disable iff (reset)
      ($countones(expected_ff) == 0) || ($countones(expected_ff) == 2))
      else $error("expected gates are not a single thyristor pair");

endmodule
`default_nettype wire

// ----- hdl/six_pulse_thyristor_firing_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Six-pulse thyristor firing sequencer. Each request transfer carries one operation in
// req_tuser (set angle, sync event, pulse on, pulse off) and yields exactly one response
// with the gate drive and the latched timing state. Sync, pulse-on and pulse-off pass
// from the idle state to the done state and load the response there. For set angle the
// sector split subtracts one 60 degree sector per cycle, then one bit-serial
// multiply-divide unit runs 16 steps for the start tick count and again for the end
// tick count. One item is in work at a time; a finished response waits in the output
// register until it is taken, and the next request is accepted once that response
// has been loaded.
module six_pulse_thyristor_firing_sequencer_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // alpha[15:0], pulse_width[27:16], sector_ticks[43:28], sync_source[46:44]
   input  wire  [tfs_pkg::REQ_W-1:0]    req_tdata,
   // opcode[1:0]
   input  wire  [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // gate_mask[5:0], time_set[21:6], time_clear[37:22], carry_flag[38],
   // angle_sector[41:39]
   output logic [tfs_pkg::RSP_W-1:0]    rsp_tdata,
   input  wire                          csr_wen,
   input  wire                          csr_index,
   input  wire                          csr_wdata
);
   import tfs_pkg::*;

   localparam logic [ANGLE_W-1:0] ANGLE_S   = ANGLE_W'(SECTOR_UNITS);
   localparam logic [PSUM_W-1:0]  PSUM_S    = PSUM_W'(SECTOR_UNITS);
   localparam logic [SUM_W-1:0]   SUM_SHIFT = SUM_W'(SHIFT_UNITS);
   localparam logic [SUM_W-1:0]   SUM_MAX   = SUM_W'(ANGLE_MAX);

   state_type           state_ff, state_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [PW_W-1:0]     pw_ff, pw_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [TICK_W-1:0]   start_ticks_ff, start_ticks_in;
   logic [TICK_W-1:0]   end_ticks_ff, end_ticks_in;
   logic                carry_ff, carry_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                reverse_ff;
   logic                semistor_ff;

   opcode_type          req_opcode;
   logic [SUM_W-1:0]    shifted;
   logic [ANGLE_W-1:0]  clamped;
   logic [PSUM_W-1:0]   pulse_sum;
   logic                end_over;
   logic [UNIT_W-1:0]   end_units;
   logic [GATE_W-1:0]   gate_mask;

   tick_ctrl_type       tick_ctrl;
   tick_stat_type       tick_stat;
   gate_ctrl_type       gate_ctrl;

   tfs_tick_unit u_tick (
      .clock (clock),
      .reset (reset),
      .ctrl  (tick_ctrl),
      .stat  (tick_stat)
   );

   tfs_gate_seq u_gate (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (gate_ctrl),
      .gate_mask (gate_mask)
   );

   assign req_opcode = opcode_type'(req_tuser);

   always_comb begin
      shifted = SUM_W'($signed(req_tdata[ALPHA_W-1:0]))
                + (semistor_ff ? '0 : SUM_SHIFT);
      if (shifted[SUM_W-1]) begin
         clamped = '0;
      end else if ($signed(shifted) > $signed(SUM_MAX)) begin
         clamped = ANGLE_W'(ANGLE_MAX);
      end else begin
         clamped = shifted[ANGLE_W-1:0];
      end
   end

   always_comb begin
      pulse_sum = PSUM_W'(angle_ff[REM_W-1:0]) + PSUM_W'(pw_ff);
      end_over  = pulse_sum > PSUM_S;
      end_units = end_over ? UNIT_W'(pulse_sum - PSUM_S) : UNIT_W'(pulse_sum);
   end

   always_comb begin
      state_in          = state_ff;
      angle_in          = angle_ff;
      pw_in             = pw_ff;
      ticks_in          = ticks_ff;
      sector_in         = sector_ff;
      start_ticks_in    = start_ticks_ff;
      end_ticks_in      = end_ticks_ff;
      carry_in          = carry_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      req_tready        = 1'b0;
      gate_ctrl.update  = 1'b0;
      gate_ctrl.opcode  = req_opcode;
      gate_ctrl.source  = req_tdata[46:44];
      gate_ctrl.sector  = sector_ff;
      gate_ctrl.carry   = carry_ff;
      gate_ctrl.reverse = reverse_ff;
      tick_ctrl.start   = 1'b0;
      tick_ctrl.units   = '0;
      tick_ctrl.ticks   = ticks_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_opcode == OP_SET_ANGLE) begin
                  angle_in  = clamped;
                  pw_in     = req_tdata[27:16];
                  ticks_in  = req_tdata[43:28];
                  sector_in = '0;
                  state_in  = ST_SECTOR;
               end else begin
                  gate_ctrl.update = 1'b1;
                  state_in         = ST_DONE;
               end
            end
         end
         ST_SECTOR: begin
            if (angle_ff >= ANGLE_S) begin
               angle_in  = angle_ff - ANGLE_S;
               sector_in = sector_ff + 1'b1;
            end else begin
               tick_ctrl.start = 1'b1;
               tick_ctrl.units = UNIT_W'(angle_ff[REM_W-1:0]);
               state_in        = ST_START;
            end
         end
         ST_START: begin
            if (tick_stat.done) begin
               start_ticks_in  = tick_stat.result;
               carry_in        = end_over;
               tick_ctrl.start = 1'b1;
               tick_ctrl.units = end_units;
               state_in        = ST_END;
            end
         end
         ST_END: begin
            if (tick_stat.done) begin
               end_ticks_in = tick_stat.result;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_W - RSP_USED_W)'(0), sector_ff, carry_ff,
                               end_ticks_ff, start_ticks_ff, gate_mask};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sector_ff      <= '0;
         start_ticks_ff <= '0;
         end_ticks_ff   <= '0;
         carry_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         reverse_ff     <= 1'b0;
         semistor_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sector_ff      <= sector_in;
         start_ticks_ff <= start_ticks_in;
         end_ticks_ff   <= end_ticks_in;
         carry_ff       <= carry_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index_type'(csr_index))
               CSR_REVERSE_SEQUENCE: reverse_ff  <= csr_wdata;
               CSR_SEMISTOR_MODE:    semistor_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      angle_ff    <= angle_in;
      pw_ff       <= pw_in;
      ticks_ff    <= ticks_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      sector_ff <= SECTOR_W'(QUEUE_LEN - 1))
      else $error("angle sector beyond the last sector");
   a_tick_done_owned: assert property (@(posedge clock) disable iff (reset)
      tick_stat.done |-> (state_ff == ST_START || state_ff == ST_END))
      else $error("tick result finished outside a set angle");
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready))
         |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not loaded into the output register");

endmodule
`default_nettype wire
